### hw/rtl/rcsfp_pkg.sv
// Shared types and constants for the RC serial frame parser.
// Depends on nothing; imported by every module of the block but rcsfp_ram.
`timescale 1ns / 1ps
package rcsfp_pkg;

	// Channels reported per channel frame.
	localparam int NUM_CHANNELS = 14;

	// Payload buffer: two banks of 16 words, each word holds two payload bytes.
	localparam int WORD_AW   = 4;
	localparam int PL_DEPTH  = 2 * (1 << WORD_AW);
	localparam int PL_AW     = $clog2(PL_DEPTH);
	localparam int PL_WIDTH  = 16;

	// Result event codes.
	localparam logic [2:0] EV_CHANNEL   = 3'd0;
	localparam logic [2:0] EV_DISCOVERY = 3'd1;
	localparam logic [2:0] EV_TYPE      = 3'd2;
	localparam logic [2:0] EV_MEASURE   = 3'd3;
	localparam logic [2:0] EV_CSUM_ERR  = 3'd4;

	typedef enum logic [1:0] {
		FK_CHANNEL = 2'd0,
		FK_DISCOVERY = 2'd1,
		FK_TYPE = 2'd2,
		FK_MEASURE = 2'd3
	} frame_kind_t;

	// One finished frame, handed from the parser to the result generator.
	typedef struct packed {
		logic        err;
		frame_kind_t kind;
		logic [3:0]  sid;
		logic        bank;
	} job_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  event_kind;
		logic [3:0]  channel_index;
		logic [15:0] value;
		logic [3:0]  sensor_id;
		logic [7:0]  sensor_type;
		logic        last;
	} res_t;

endpackage

### hw/rtl/rc_serial_frame_parser.sv
// Top level of the RC serial frame parser: parser front, job queue,
// payload RAM and result generator. Uses rcsfp_pkg and all rcsfp_* modules.
`timescale 1ns / 1ps
//
//  channel  | handshake    | payload
//  ---------+--------------+------------------------------------------------
//  bytes in | push / full  | rx_byte
//  results  | empty / pop  | event_kind, channel_index, value, sensor_id,
//           |              | sensor_type, last
//
//  A byte is taken every cycle while full is low; full rises only when two
//  finished frames are waiting on the result generator (one per payload bank).
//  A sensor or error frame yields a single result; a good channel frame yields
//  NUM_CHANNELS results at one per cycle while results are popped, paced by
//  the single read port of the payload RAM.
//  Reset (arst_n low) clears the parser position, the job queue and the result
//  valid flag; the payload RAM is not cleared, every word read is written first.
//  A stalled result (pop low) holds the generator; the parser keeps taking
//  bytes until the job queue fills.
module rc_serial_frame_parser import rcsfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_kind,
	output logic [3:0]  channel_index,
	output logic [15:0] value,
	output logic [3:0]  sensor_id,
	output logic [7:0]  sensor_type,
	output logic        last
);

	logic                byte_valid;
	logic                ram_we;
	logic [PL_AW-1:0]    ram_waddr;
	logic [PL_WIDTH-1:0] ram_wdata;
	logic                ram_re;
	logic [PL_AW-1:0]    ram_raddr;
	logic [PL_WIDTH-1:0] ram_rdata;
	logic                job_push;
	job_t                job_in;
	logic                job_pop;
	logic                job_valid;
	job_t                job_head;
	res_t                res;
	logic                res_valid;

	// Accept a byte only while the job queue has room.
	assign byte_valid = push && !full;

	rcsfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_data  (rx_byte),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.job_push   (job_push),
		.job_data   (job_in)
	);

	// Two banks: the parser fills one while the generator drains the other.
	rcsfp_ram #(
		.WIDTH (PL_WIDTH),
		.DEPTH (PL_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rcsfp_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (full),
		.pop       (job_pop),
		.valid     (job_valid),
		.head      (job_head)
	);

	rcsfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_head),
		.job_pop   (job_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (pop)
	);

	// Present the waiting result.
	assign empty         = !res_valid;
	assign event_kind    = res.event_kind;
	assign channel_index = res.channel_index;
	assign value         = res.value;
	assign sensor_id     = res.sensor_id;
	assign sensor_type   = res.sensor_type;
	assign last          = res.last;

endmodule

### hw/rtl/rcsfp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module rcsfp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/rcsfp_front.sv
// Byte parser: tracks frame position, checks command and checksum,
// writes payload words into the payload RAM. Uses rcsfp_pkg.
`timescale 1ns / 1ps
module rcsfp_front import rcsfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic [7:0]         byte_data,
	output logic               ram_we,
	output logic [PL_AW-1:0]   ram_waddr,
	output logic [PL_WIDTH-1:0] ram_wdata,
	output logic               job_push,
	output job_t               job_data
);

	localparam logic [7:0] CMD_CHANNEL = 8'h40;
	localparam logic [7:0] LEN_CHANNEL = 8'h20;
	localparam logic [7:0] LEN_DISC    = 8'd4;
	localparam logic [7:0] LEN_SENSOR  = 8'd6;
	localparam logic [3:0] HI_DISC     = 4'h8;
	localparam logic [3:0] HI_TYPE     = 4'h9;
	localparam logic [3:0] HI_MEAS     = 4'hA;

	logic [5:0]  pos_q;
	logic [7:0]  len_q;
	frame_kind_t kind_q;
	logic [3:0]  sid_q;
	logic [15:0] acc_q;
	logic [7:0]  sum_lo_q;
	logic [7:0]  lo_byte_q;
	logic        bank_q;

	logic [7:0]  pos8;
	logic [5:0]  pidx;
	logic        cmd_ok;
	frame_kind_t cmd_kind;
	logic        in_payload;
	logic        at_sum_lo;
	logic [15:0] acc_next;

	assign pos8       = {2'b00, pos_q};
	assign pidx       = pos_q - 6'd2;
	assign in_payload = (pos8 + 8'd2) < len_q;
	assign at_sum_lo  = (pos8 + 8'd2) == len_q;
	assign acc_next   = acc_q + {8'h00, byte_data};

	// Command classification: command byte and length must agree.
	always_comb begin
		cmd_ok   = 1'b1;
		cmd_kind = FK_CHANNEL;
		if (byte_data == CMD_CHANNEL && len_q == LEN_CHANNEL) begin
			cmd_kind = FK_CHANNEL;
		end else if (byte_data[7:4] == HI_DISC && len_q == LEN_DISC) begin
			cmd_kind = FK_DISCOVERY;
		end else if (byte_data[7:4] == HI_TYPE && len_q == LEN_SENSOR) begin
			cmd_kind = FK_TYPE;
		end else if (byte_data[7:4] == HI_MEAS && len_q == LEN_SENSOR) begin
			cmd_kind = FK_MEASURE;
		end else begin
			cmd_ok = 1'b0;
		end
	end

	// Write a payload word on every odd payload byte.
	assign ram_we    = byte_valid && pos_q > 6'd1 && in_payload && pidx[0];
	assign ram_waddr = {bank_q, pidx[WORD_AW:1]};
	assign ram_wdata = {byte_data, lo_byte_q};

	assign job_push      = byte_valid && pos_q > 6'd1 && !in_payload && !at_sum_lo;
	assign job_data.err  = ({byte_data, sum_lo_q} != ~acc_q) || ((pos8 + 8'd1) != len_q);
	assign job_data.kind = kind_q;
	assign job_data.sid  = sid_q;
	assign job_data.bank = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			kind_q <= FK_CHANNEL;
			sid_q  <= '0;
			acc_q  <= '0;
			sum_lo_q <= '0;
			bank_q <= 1'b0;
		end else if (byte_valid) begin
			if (pos_q == 6'd0) begin
				len_q <= byte_data;
				acc_q <= {8'h00, byte_data};
				pos_q <= 6'd1;
			end else if (pos_q == 6'd1) begin
				if (cmd_ok) begin
					kind_q <= cmd_kind;
					sid_q  <= byte_data[3:0];
					acc_q  <= acc_next;
					pos_q  <= 6'd2;
				end else begin
					// resync: treat as a fresh length byte
					len_q <= byte_data;
					acc_q <= {8'h00, byte_data};
				end
			end else if (in_payload) begin
				acc_q <= acc_next;
				pos_q <= pos_q + 6'd1;
			end else if (at_sum_lo) begin
				sum_lo_q <= byte_data;
				pos_q    <= pos_q + 6'd1;
			end else begin
				pos_q  <= '0;
				bank_q <= ~bank_q;
			end
		end
	end

	// Hold the even payload byte until its partner arrives.
	always_ff @(posedge clk) begin
		if (byte_valid && pos_q > 6'd1 && in_payload && !pidx[0]) begin
			lo_byte_q <= byte_data;
		end
	end

endmodule

### hw/rtl/rcsfp_jobq.sv
// Two-entry queue of finished-frame jobs between parser and result generator.
// Uses rcsfp_pkg.
`timescale 1ns / 1ps
module rcsfp_jobq import rcsfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t head
);

	job_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/rcsfp_back.sv
// Result generator: turns a job into one or NUM_CHANNELS result items,
// reading payload words from RAM when the job needs them. Uses rcsfp_pkg.
`timescale 1ns / 1ps
module rcsfp_back import rcsfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  job_t                job,
	output logic                job_pop,
	output logic                ram_re,
	output logic [PL_AW-1:0]    ram_raddr,
	input  logic [PL_WIDTH-1:0] ram_rdata,
	output res_t                res,
	output logic                res_valid,
	input  logic                res_take
);

	typedef enum logic {
		B_IDLE,
		B_READ
	} bstate_t;

	localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

	bstate_t    state_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	res_t       out_q;

	logic slot_free;
	logic needs_data;
	logic last_res;
	res_t nxt;

	assign slot_free  = !out_valid_q || res_take;
	assign needs_data = !job.err && job.kind != FK_DISCOVERY;
	assign last_res   = job.kind != FK_CHANNEL || idx_q == LAST_CH;

	// Build the result for the current job and channel index.
	always_comb begin
		nxt = '0;
		nxt.last = 1'b1;
		if (job.err) begin
			nxt.event_kind = EV_CSUM_ERR;
		end else begin
			unique case (job.kind)
				FK_CHANNEL: begin
					nxt.event_kind    = EV_CHANNEL;
					nxt.channel_index = idx_q;
					nxt.value         = ram_rdata;
					nxt.last          = idx_q == LAST_CH;
				end
				FK_DISCOVERY: begin
					nxt.event_kind = EV_DISCOVERY;
					nxt.sensor_id  = job.sid;
				end
				FK_TYPE: begin
					nxt.event_kind  = EV_TYPE;
					nxt.sensor_id   = job.sid;
					nxt.sensor_type = ram_rdata[7:0];
				end
				default: begin
					nxt.event_kind = EV_MEASURE;
					nxt.sensor_id  = job.sid;
					nxt.value      = ram_rdata;
				end
			endcase
		end
	end

	always_comb begin
		job_pop   = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = {job.bank, idx_q};
		unique case (state_q)
			B_IDLE: begin
				if (job_valid && needs_data) begin
					ram_re = 1'b1;
				end else if (job_valid && slot_free) begin
					job_pop = 1'b1;
				end
			end
			B_READ: begin
				if (slot_free) begin
					if (last_res) begin
						job_pop = 1'b1;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = {job.bank, idx_q + 4'd1};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (job_valid && needs_data) begin
						state_q <= B_READ;
						// drop a result that leaves while the first word is read
						if (res_take) begin
							out_valid_q <= 1'b0;
						end
					end else if (job_valid && slot_free) begin
						out_valid_q <= 1'b1;
					end else if (res_take) begin
						out_valid_q <= 1'b0;
					end
				end
				B_READ: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (last_res) begin
							state_q <= B_IDLE;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Result register: load whenever a result is produced.
	always_ff @(posedge clk) begin
		if ((state_q == B_IDLE && job_valid && !needs_data && slot_free) ||
		    (state_q == B_READ && slot_free)) begin
			out_q <= nxt;
		end
	end

	assign res       = out_q;
	assign res_valid = out_valid_q;

endmodule

### bench/testbench.sv
// Self-checking bench for rc_serial_frame_parser: builds byte streams of good,
// corrupted and broken frames, predicts every result and checks it on the fly.
// Depends on rcsfp_pkg and the rc_serial_frame_parser RTL.
`timescale 1ns / 1ps
module testbench;
	import rcsfp_pkg::*;

	// Payload patterns used when building frames.
	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES,
		FILL_SPLIT
	} fill_t;

	// One byte waiting to be offered, tagged with the idle phase it belongs to.
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] phase;
	} rx_item_t;

	localparam int RX_TARGET = 370;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 400;

	// Idle percentages per phase: none, sender only, receiver only, both.
	int unsigned send_idle [4] = '{0, 47, 0, 26};
	int unsigned recv_stall [4] = '{0, 0, 47, 26};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  rx_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  event_kind;
	logic [3:0]  channel_index;
	logic [15:0] value;
	logic [3:0]  sensor_id;
	logic [7:0]  sensor_type;
	logic        last;

	rx_item_t rx_backlog [$];
	res_t     due_results [$];

	int  bytes_queued = 0;
	int  bytes_taken = 0;
	int  results_predicted = 0;
	int  results_checked = 0;
	int  errors = 0;
	int  full_stalls = 0;
	int  kind_count [8];
	bit  rx_took = 1'b0;
	bit  hold_off = 1'b0;
	logic [1:0] cur_phase = 2'd0;

	// Shadow copy of the parser state.
	logic [5:0]   fp_pos = '0;
	logic [7:0]   fp_len = '0;
	frame_kind_t  fp_kind = FK_CHANNEL;
	logic [7:0]   fp_cmd = '0;
	logic [7:0]   fp_payload [0:27];
	logic [15:0]  fp_csum = '0;

	rc_serial_frame_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rx_byte       (rx_byte),
		.empty         (empty),
		.pop           (pop),
		.event_kind    (event_kind),
		.channel_index (channel_index),
		.value         (value),
		.sensor_id     (sensor_id),
		.sensor_type   (sensor_type),
		.last          (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Advance the shadow parser by one byte and queue whatever results it yields.
	task automatic parse_rx_byte(input logic [7:0] b);
		int    p;
		int    l;
		int    n;
		int    i;
		bit    good;
		logic [15:0] s;
		res_t  r;
		p = fp_pos;
		l = fp_len;
		if (p == 0) begin
			fp_len = b;
			fp_pos = 6'd1;
		end else if (p == 1) begin
			// An unknown command/length pair turns the byte into a new length.
			good = 1'b1;
			if (b == 8'h40 && l == 8'h20)
				fp_kind = FK_CHANNEL;
			else if (b[7:4] == 4'h8 && l == 4)
				fp_kind = FK_DISCOVERY;
			else if (b[7:4] == 4'h9 && l == 6)
				fp_kind = FK_TYPE;
			else if (b[7:4] == 4'hA && l == 6)
				fp_kind = FK_MEASURE;
			else
				good = 1'b0;
			if (good) begin
				fp_cmd = b;
				fp_pos = 6'd2;
			end else begin
				fp_len = b;
			end
		end else if (p + 2 < l) begin
			if (p - 2 < 28)
				fp_payload[p - 2] = b;
			fp_pos = 6'(p + 1);
		end else if (p + 2 == l) begin
			fp_csum = {8'h00, b};
			fp_pos = 6'(p + 1);
		end else begin
			// Closing checksum byte: verify the frame, then emit its results.
			fp_csum[15:8] = b;
			fp_pos = 6'd0;
			n = (l >= 4) ? l - 4 : 0;
			if (n > 28)
				n = 28;
			s = 16'hFFFF - fp_len - fp_cmd;
			for (i = 0; i < n; i++)
				s = s - fp_payload[i];
			r = '0;
			r.last = 1'b1;
			if (p + 1 != l || s != fp_csum) begin
				r.event_kind = EV_CSUM_ERR;
				due_results.push_back(r);
			end else begin
				case (fp_kind)
					FK_CHANNEL: begin
						for (i = 0; i < NUM_CHANNELS; i++) begin
							r.event_kind = EV_CHANNEL;
							r.channel_index = 4'(i);
							r.value = {fp_payload[2 * i + 1], fp_payload[2 * i]};
							r.last = (i == NUM_CHANNELS - 1);
							due_results.push_back(r);
						end
					end
					FK_DISCOVERY: begin
						r.event_kind = EV_DISCOVERY;
						r.sensor_id = fp_cmd[3:0];
						due_results.push_back(r);
					end
					FK_TYPE: begin
						r.event_kind = EV_TYPE;
						r.sensor_id = fp_cmd[3:0];
						r.sensor_type = fp_payload[0];
						due_results.push_back(r);
					end
					default: begin
						r.event_kind = EV_MEASURE;
						r.sensor_id = fp_cmd[3:0];
						r.value = {fp_payload[1], fp_payload[0]};
						due_results.push_back(r);
					end
				endcase
			end
		end
		results_predicted = due_results.size() + results_checked;
	endtask

	task automatic add_byte(input logic [7:0] b, input int ph);
		rx_item_t it;
		it.data = b;
		it.phase = 2'(ph);
		rx_backlog.push_back(it);
		bytes_queued++;
	endtask

	// Build one frame with a valid checksum; optionally flip one bit after the
	// command byte so the checksum fails, or send only its first cut bytes.
	task automatic emit_frame(input frame_kind_t k, input logic [3:0] sid,
			input fill_t fill, input bit corrupt, input int cut, input int ph);
		logic [7:0]  fr [$];
		logic [7:0]  flen;
		logic [7:0]  cmd;
		logic [7:0]  pb;
		logic [15:0] sum;
		int          i;
		int          n;
		case (k)
			FK_CHANNEL: begin
				flen = 8'h20;
				cmd = 8'h40;
			end
			FK_DISCOVERY: begin
				flen = 8'h04;
				cmd = {4'h8, sid};
			end
			FK_TYPE: begin
				flen = 8'h06;
				cmd = {4'h9, sid};
			end
			default: begin
				flen = 8'h06;
				cmd = {4'hA, sid};
			end
		endcase
		fr.push_back(flen);
		fr.push_back(cmd);
		for (i = 0; i < flen - 4; i++) begin
			case (fill)
				FILL_ZERO:  pb = 8'h00;
				FILL_ONES:  pb = 8'hFF;
				FILL_SPLIT: pb = i[1] ? 8'hFF : 8'h00;
				default:    pb = 8'($urandom);
			endcase
			fr.push_back(pb);
		end
		sum = 16'h0000;
		foreach (fr[j])
			sum = sum + fr[j];
		sum = 16'hFFFF - sum;
		fr.push_back(sum[7:0]);
		fr.push_back(sum[15:8]);
		if (corrupt) begin
			i = $urandom_range(2, fr.size() - 1);
			fr[i] = fr[i] ^ 8'(1 << $urandom_range(0, 7));
		end
		n = (cut > 0 && cut < fr.size()) ? cut : fr.size();
		for (i = 0; i < n; i++)
			add_byte(fr[i], ph);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Driver: change inputs on the falling edge. Hold an offered byte until it
	// is taken; drop push on a sender idle cycle.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!push || rx_took) begin
				if (rx_backlog.size() != 0 &&
						$urandom_range(0, 99) >= send_idle[rx_backlog[0].phase]) begin
					push <= 1'b1;
					rx_byte <= rx_backlog[0].data;
					cur_phase = rx_backlog[0].phase;
				end else begin
					push <= 1'b0;
				end
			end
			rx_took = 1'b0;
			pop <= !hold_off && ($urandom_range(0, 99) >= recv_stall[cur_phase]);
		end
	end

	// Monitor: on the rising edge check a popped result against the oldest
	// prediction, then feed an accepted byte into the shadow parser.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with none expected: expected nothing, actual kind %0d ch %0d value %0h",
						$time, event_kind, channel_index, value);
					errors++;
				end else begin
					res_t want;
					want = due_results.pop_front();
					check_field("event_kind", want.event_kind, event_kind);
					check_field("channel_index", want.channel_index, channel_index);
					check_field("value", want.value, value);
					check_field("sensor_id", want.sensor_id, sensor_id);
					check_field("sensor_type", want.sensor_type, sensor_type);
					check_field("last", want.last, last);
					kind_count[event_kind]++;
					results_checked++;
				end
			end
			if (push && full)
				full_stalls++;
			if (push && !full) begin
				parse_rx_byte(rx_byte);
				void'(rx_backlog.pop_front());
				bytes_taken++;
				rx_took = 1'b1;
			end
		end
	end

	// Back pressure: hold the receiver off long enough for the job queue to
	// fill and raise full while the sender keeps offering bytes.
	initial begin
		wait (bytes_taken >= 40);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results still due", due_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int    ph;
		int    r;
		fill_t f;
		foreach (kind_count[k])
			kind_count[k] = 0;

		// Directed: each sensor kind at its field extremes, a corrupted
		// checksum, and an invalid command that forces a resync.
		emit_frame(FK_DISCOVERY, 4'h0, FILL_ZERO, 1'b0, 0, 0);
		emit_frame(FK_TYPE, 4'hF, FILL_ONES, 1'b0, 0, 0);
		emit_frame(FK_MEASURE, 4'h5, FILL_ZERO, 1'b0, 0, 0);
		emit_frame(FK_DISCOVERY, 4'hA, FILL_ZERO, 1'b1, 0, 0);
		add_byte(8'h06, 0);
		add_byte(8'h40, 0);
		emit_frame(FK_DISCOVERY, 4'hC, FILL_ZERO, 1'b0, 0, 0);

		// Random: mostly well-formed frames with random content, the rest
		// corrupted frames, cut-off frames and loose noise bytes.
		while (bytes_queued < RX_TARGET) begin
			ph = (bytes_queued * 4) / RX_TARGET;
			if (ph > 3)
				ph = 3;
			f = ($urandom_range(0, 9) < 8) ? FILL_RANDOM : fill_t'($urandom_range(1, 3));
			r = $urandom_range(0, 99);
			if (r < 80)
				emit_frame(frame_kind_t'(r / 20), 4'($urandom), f, 1'b0, 0, ph);
			else if (r < 88)
				emit_frame(frame_kind_t'($urandom_range(0, 3)), 4'($urandom), f, 1'b1, 0, ph);
			else if (r < 94)
				repeat ($urandom_range(1, 3)) add_byte(8'($urandom), ph);
			else
				emit_frame(frame_kind_t'($urandom_range(0, 3)), 4'($urandom), f, 1'b0,
					$urandom_range(1, 5), ph);
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		wait (bytes_taken == bytes_queued);
		wait (results_checked == results_predicted);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, due_results.size());
			errors++;
		end

		$display("Fed %0d bytes over four idle phases; input stalled on full for %0d cycles.",
			bytes_taken, full_stalls);
		$display("Checked %0d results: %0d channel, %0d discovery, %0d type, %0d measure, %0d bad checksum.",
			results_checked, kind_count[EV_CHANNEL], kind_count[EV_DISCOVERY],
			kind_count[EV_TYPE], kind_count[EV_MEASURE], kind_count[EV_CSUM_ERR]);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
